// ===== rtl/wec_pkg.sv =====
// Shared types, constants and codes of the wheel encoder count and speed block.
package wec_pkg;

  localparam int WHEELS_DEF = 2;
  localparam int WHEEL_W    = 3;
  localparam int CNT_W      = 16;
  localparam int SPD_W      = 32;
  localparam int CFG_W      = 16;
  localparam int MASK_W     = 8;
  localparam int MS_W       = 16;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam int ACC_W      = 58;
  localparam int Q_W        = 39;
  localparam int DIVR_W     = 32;
  localparam int STEP_W     = 6;
  localparam int DIFF_W     = 41;
  localparam int RAW_W      = 40;
  localparam int UPD_W      = ACC_W - 16;
  localparam int SUM_W      = UPD_W + 1;

  localparam logic [ACC_W-1:0]  RPM_SCALE_Q8 = ACC_W'(15360000);
  localparam logic [STEP_W-1:0] MUL_STEPS    = STEP_W'(16);
  localparam logic [STEP_W-1:0] DIV_STEPS    = STEP_W'(Q_W);

  localparam logic [CFG_W-1:0]  PPR_RST   = 16'd13;
  localparam logic [CFG_W-1:0]  ALPHA_RST = 16'd16384;
  localparam logic [MASK_W-1:0] INV_RST   = 8'd2;

  localparam logic [1:0] REG_PPR   = 2'd0;
  localparam logic [1:0] REG_ALPHA = 2'd1;
  localparam logic [1:0] REG_INV   = 2'd2;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } wec_op_t;

  typedef struct packed {
    logic              start;
    wec_op_t           op;
    logic [STEP_W-1:0] steps;
  } wec_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wec_stat_t;

  typedef struct packed {
    logic [CFG_W-1:0]  ppr;
    logic [CFG_W-1:0]  alpha;
    logic [MASK_W-1:0] inv;
  } wec_cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVP,
    S_LOAD,
    S_SCALE,
    S_DIV,
    S_DIFF,
    S_ALPHA,
    S_EMIT
  } wec_state_t;

endpackage

// ===== rtl/wec_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface wec_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [wec_pkg::WHEEL_W-1:0]   wheel;
  logic                          b_level;
  logic [wec_pkg::MS_W-1:0]      elapsed_ms;

  modport source (output valid, mode, wheel, b_level, elapsed_ms, input ready);
  modport sink   (input valid, mode, wheel, b_level, elapsed_ms, output ready);
endinterface

interface wec_out_if;
  logic                               valid;
  logic                               ready;
  logic [wec_pkg::WHEEL_W-1:0]        wheel_out;
  logic signed [wec_pkg::CNT_W-1:0]   pulse_count;
  logic signed [wec_pkg::SPD_W-1:0]   speed_rpm_q8;
  logic                               last_of_run;

  modport source (output valid, wheel_out, pulse_count, speed_rpm_q8, last_of_run,
                  input ready);
  modport sink   (input valid, wheel_out, pulse_count, speed_rpm_q8, last_of_run,
                  output ready);
endinterface

// ===== rtl/wec_regs.sv =====
// APB configuration registers: pulses per revolution, filter weight, invert mask.
module wec_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wec_pkg::PADDR_W-1:0]   paddr,
  input  logic [wec_pkg::PDATA_W-1:0]   pwdata,
  output logic [wec_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output wec_pkg::wec_cfg_t             cfg
);

  wec_pkg::wec_cfg_t cfg_r;
  logic              wr_en;
  logic [1:0]        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.ppr   <= wec_pkg::PPR_RST;
      cfg_r.alpha <= wec_pkg::ALPHA_RST;
      cfg_r.inv   <= wec_pkg::INV_RST;
    end else if (wr_en) begin
      case (reg_sel)
        wec_pkg::REG_PPR:   cfg_r.ppr   <= pwdata[wec_pkg::CFG_W-1:0];
        wec_pkg::REG_ALPHA: cfg_r.alpha <= pwdata[wec_pkg::CFG_W-1:0];
        wec_pkg::REG_INV:   cfg_r.inv   <= pwdata[wec_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      wec_pkg::REG_PPR:   prdata = wec_pkg::PDATA_W'(cfg_r.ppr);
      wec_pkg::REG_ALPHA: prdata = wec_pkg::PDATA_W'(cfg_r.alpha);
      wec_pkg::REG_INV:   prdata = wec_pkg::PDATA_W'(cfg_r.inv);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== rtl/wec_unit.sv =====
// Shared iterative arithmetic unit: shift-add multiply and restoring divide, one bit a cycle.
module wec_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  wec_pkg::wec_cmd_t           cmd,
  input  logic [wec_pkg::ACC_W-1:0]   a,
  input  logic [wec_pkg::Q_W-1:0]     b,
  output wec_pkg::wec_stat_t          stat,
  output logic [wec_pkg::ACC_W-1:0]   acc,
  output logic [wec_pkg::Q_W-1:0]     q
);

  logic [wec_pkg::ACC_W-1:0]  mcand;
  logic [wec_pkg::STEP_W-1:0] cnt;
  wec_pkg::wec_op_t           op_r;
  logic                       busy;
  logic                       done;
  logic [wec_pkg::ACC_W-1:0]  add_a;
  logic [wec_pkg::ACC_W-1:0]  add_b;
  logic [wec_pkg::ACC_W-1:0]  sum;
  logic                       neg;
  logic                       last_step;

  assign last_step = busy && (cnt == wec_pkg::STEP_W'(1));
  assign stat.busy = busy;
  assign stat.done = done;

  always_comb begin
    if (op_r == wec_pkg::OP_DIV) begin
      add_a = wec_pkg::ACC_W'({acc[wec_pkg::DIVR_W-1:0], q[wec_pkg::Q_W-1]});
      add_b = ~mcand;
    end else begin
      add_a = acc;
      add_b = mcand;
    end
    sum = add_a + add_b + wec_pkg::ACC_W'(op_r == wec_pkg::OP_DIV);
    neg = sum[wec_pkg::ACC_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= last_step;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (last_step) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc   <= '0;
      mcand <= a;
      q     <= b;
      cnt   <= cmd.steps;
      op_r  <= cmd.op;
    end else if (busy) begin
      cnt <= cnt - wec_pkg::STEP_W'(1);
      case (op_r)
        wec_pkg::OP_MUL: begin
          if (q[0]) begin
            acc <= sum;
          end
          mcand <= mcand << 1;
          q     <= q >> 1;
        end
        wec_pkg::OP_DIV: begin
          acc <= neg ? add_a : sum;
          q   <= {q[wec_pkg::Q_W-2:0], ~neg};
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/wheel_encoder_count_and_speed_core.sv =====
// Wheel encoder count and speed block: sequencer, per-wheel state and output register.
// Edge item: result registered in the cycle after acceptance; ready again at once unless the output stalls.
// Update item: worked through on the one-bit-a-cycle shared multiply/divide unit
// (16-step multiplies, 39-step divide) used per wheel; output stalls can hold it.
// One item at a time; an update with zero elapsed time is accepted and gives no result.
// Synchronous reset clears counts and speeds, restores configuration defaults and resets the sequencer.
module wheel_encoder_count_and_speed_core #(
  parameter int WHEELS = wec_pkg::WHEELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  wec_in_if.sink                        din,
  wec_out_if.source                     dout,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wec_pkg::PADDR_W-1:0]   paddr,
  input  logic [wec_pkg::PDATA_W-1:0]   pwdata,
  output logic [wec_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int IW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

  wec_pkg::wec_cfg_t   cfg;
  wec_pkg::wec_cmd_t   cmd;
  wec_pkg::wec_stat_t  ustat;
  wec_pkg::wec_state_t state, state_next;

  logic [wec_pkg::ACC_W-1:0] u_a;
  logic [wec_pkg::Q_W-1:0]   u_b;
  logic [wec_pkg::ACC_W-1:0] u_acc;
  logic [wec_pkg::Q_W-1:0]   u_q;

  logic [wec_pkg::CNT_W-1:0]        counts [WHEELS];
  logic [wec_pkg::CNT_W-1:0]        prevs  [WHEELS];
  logic signed [wec_pkg::SPD_W-1:0] speeds [WHEELS];

  logic [IW-1:0]                    idx;
  logic [wec_pkg::DIVR_W-1:0]       divisor;
  logic [wec_pkg::CNT_W-1:0]        cnt_r;
  logic signed [wec_pkg::SPD_W-1:0] spd_r;
  logic signed [wec_pkg::SPD_W-1:0] spd_new;
  logic                             neg_r;
  logic signed [wec_pkg::DIFF_W-1:0] diff;

  logic                             o_valid;
  logic [wec_pkg::WHEEL_W-1:0]      o_wheel;
  logic [wec_pkg::CNT_W-1:0]        o_count;
  logic signed [wec_pkg::SPD_W-1:0] o_speed;
  logic                             o_last;

  logic                             out_free;
  logic                             accept;
  logic                             emit_edge;
  logic                             emit_wheel;
  logic                             is_last;
  logic                             present;
  logic [IW-1:0]                    eidx;
  logic [wec_pkg::CNT_W-1:0]        cnt_step;
  logic [wec_pkg::CNT_W-1:0]        delta;
  logic [wec_pkg::CNT_W-1:0]        mag;
  logic [wec_pkg::CFG_W-1:0]        ppr_eff;
  logic signed [wec_pkg::RAW_W-1:0]  raw;
  logic signed [wec_pkg::DIFF_W-1:0] diff_next;
  logic signed [wec_pkg::UPD_W-1:0]  upd;
  logic signed [wec_pkg::SUM_W-1:0]  sum_s;
  logic signed [wec_pkg::SPD_W-1:0]  sat;

  wec_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wec_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .a    (u_a),
    .b    (u_b),
    .stat (ustat),
    .acc  (u_acc),
    .q    (u_q)
  );

  assign dout.valid        = o_valid;
  assign dout.wheel_out    = o_wheel;
  assign dout.pulse_count  = o_count;
  assign dout.speed_rpm_q8 = o_speed;
  assign dout.last_of_run  = o_last;

  assign out_free = !o_valid || dout.ready;
  assign accept   = din.valid && din.ready;
  assign present  = ({1'b0, din.wheel} < (wec_pkg::WHEEL_W + 1)'(WHEELS));
  assign eidx     = din.wheel[IW-1:0];
  assign cnt_step = (din.b_level ^ cfg.inv[din.wheel]) ? counts[eidx] + 16'd1
                                                       : counts[eidx] - 16'd1;
  assign ppr_eff  = (cfg.ppr == '0) ? wec_pkg::CFG_W'(1) : cfg.ppr;
  assign delta    = counts[idx] - prevs[idx];
  assign mag      = delta[wec_pkg::CNT_W-1] ? wec_pkg::CNT_W'(-delta) : delta;
  assign is_last  = (idx == IW'(WHEELS - 1));

  // Sign-restore the quotient, then form the filter error against the held speed
  assign raw       = neg_r ? -$signed({1'b0, u_q}) : $signed({1'b0, u_q});
  assign diff_next = wec_pkg::DIFF_W'(raw) - wec_pkg::DIFF_W'(spd_r);

  // Floor shift by 16 of the weighted error, then saturating add to the speed
  assign upd   = $signed(u_acc[wec_pkg::ACC_W-1:16]);
  assign sum_s = wec_pkg::SUM_W'(spd_r) + wec_pkg::SUM_W'(upd);

  always_comb begin
    if (sum_s > wec_pkg::SUM_W'(32'sh7fffffff)) begin
      sat = 32'sh7fffffff;
    end else if (sum_s < -wec_pkg::SUM_W'(33'sh080000000)) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum_s[wec_pkg::SPD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wec_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.start  = 1'b0;
    cmd.op     = wec_pkg::OP_MUL;
    cmd.steps  = wec_pkg::MUL_STEPS;
    u_a        = '0;
    u_b        = '0;
    din.ready  = 1'b0;
    emit_edge  = 1'b0;
    emit_wheel = 1'b0;
    case (state)
      wec_pkg::S_IDLE: begin
        din.ready = out_free;
        if (din.valid && out_free) begin
          if (!din.mode) begin
            emit_edge = 1'b1;
          end else if (din.elapsed_ms != '0) begin
            cmd.start  = 1'b1;
            u_a        = wec_pkg::ACC_W'(ppr_eff);
            u_b        = wec_pkg::Q_W'(din.elapsed_ms);
            state_next = wec_pkg::S_DIVP;
          end
        end
      end
      wec_pkg::S_DIVP: begin
        if (ustat.done) begin
          state_next = wec_pkg::S_LOAD;
        end
      end
      wec_pkg::S_LOAD: begin
        cmd.start  = 1'b1;
        u_a        = wec_pkg::RPM_SCALE_Q8;
        u_b        = wec_pkg::Q_W'(mag);
        state_next = wec_pkg::S_SCALE;
      end
      wec_pkg::S_SCALE: begin
        if (ustat.done) begin
          cmd.start  = 1'b1;
          cmd.op     = wec_pkg::OP_DIV;
          cmd.steps  = wec_pkg::DIV_STEPS;
          u_a        = wec_pkg::ACC_W'(divisor);
          u_b        = u_acc[wec_pkg::Q_W-1:0];
          state_next = wec_pkg::S_DIV;
        end
      end
      wec_pkg::S_DIV: begin
        if (ustat.done) begin
          state_next = wec_pkg::S_DIFF;
        end
      end
      wec_pkg::S_DIFF: begin
        cmd.start  = 1'b1;
        u_a        = wec_pkg::ACC_W'(diff);
        u_b        = wec_pkg::Q_W'(cfg.alpha);
        state_next = wec_pkg::S_ALPHA;
      end
      wec_pkg::S_ALPHA: begin
        if (ustat.done) begin
          state_next = wec_pkg::S_EMIT;
        end
      end
      wec_pkg::S_EMIT: begin
        if (out_free) begin
          emit_wheel = 1'b1;
          state_next = is_last ? wec_pkg::S_IDLE : wec_pkg::S_LOAD;
        end
      end
      default: state_next = wec_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      idx     <= '0;
      for (int i = 0; i < WHEELS; i++) begin
        counts[i] <= '0;
        prevs[i]  <= '0;
        speeds[i] <= '0;
      end
    end else begin
      if (emit_edge || emit_wheel) begin
        o_valid <= 1'b1;
      end else if (dout.ready) begin
        o_valid <= 1'b0;
      end
      if (emit_edge) begin
        o_wheel <= din.wheel;
        o_last  <= 1'b1;
        if (present) begin
          counts[eidx] <= cnt_step;
          o_count      <= cnt_step;
          o_speed      <= speeds[eidx];
        end else begin
          o_count <= '0;
          o_speed <= '0;
        end
      end
      if (state == wec_pkg::S_DIVP && ustat.done) begin
        divisor <= u_acc[wec_pkg::DIVR_W-1:0];
        idx     <= '0;
      end
      if (state == wec_pkg::S_LOAD) begin
        cnt_r <= counts[idx];
        spd_r <= speeds[idx];
        neg_r <= delta[wec_pkg::CNT_W-1];
      end
      if (state == wec_pkg::S_DIV && ustat.done) begin
        diff <= diff_next;
      end
      if (state == wec_pkg::S_ALPHA && ustat.done) begin
        spd_new     <= sat;
        speeds[idx] <= sat;
        prevs[idx]  <= cnt_r;
      end
      if (emit_wheel) begin
        o_wheel <= wec_pkg::WHEEL_W'(idx);
        o_count <= cnt_r;
        o_speed <= spd_new;
        o_last  <= is_last;
        if (!is_last) begin
          idx <= idx + IW'(1);
        end
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !ustat.busy)
    else $error("arithmetic unit restarted while busy");

  a_edge_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !din.mode) |=> (dout.valid && dout.last_of_run))
    else $error("edge transaction gave no final result");

  a_update_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && din.mode && din.elapsed_ms != '0) |=> (!din.ready && !ustat.done))
    else $error("update transaction did not hold the input side");

endmodule

// ===== dv/wheel_encoder_count_and_speed_core_test.sv =====
// Self-checking test of the wheel encoder count and speed core with a predicting scoreboard.
`timescale 1ns / 100ps

class wheel_speed_board;
  typedef struct {
    logic [wec_pkg::WHEEL_W-1:0] wheel;
    logic [wec_pkg::CNT_W-1:0]   cnt;
    logic [wec_pkg::SPD_W-1:0]   spd;
    logic                        last;
  } wheel_report_t;

  logic [wec_pkg::CFG_W-1:0]  ppr;
  logic [wec_pkg::CFG_W-1:0]  alpha;
  logic [wec_pkg::MASK_W-1:0] inv;
  logic [wec_pkg::CNT_W-1:0]        counts [wec_pkg::WHEELS_DEF];
  logic [wec_pkg::CNT_W-1:0]        marks  [wec_pkg::WHEELS_DEF];
  logic signed [wec_pkg::SPD_W-1:0] speeds [wec_pkg::WHEELS_DEF];
  wheel_report_t awaited [$];
  int errors;
  int compared;
  int clamps;

  function new();
    ppr      = wec_pkg::PPR_RST;
    alpha    = wec_pkg::ALPHA_RST;
    inv      = wec_pkg::INV_RST;
    errors   = 0;
    compared = 0;
    clamps   = 0;
    for (int i = 0; i < wec_pkg::WHEELS_DEF; i++) begin
      counts[i] = '0;
      marks[i]  = '0;
      speeds[i] = '0;
    end
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      wec_pkg::REG_PPR:   ppr   = val[15:0];
      wec_pkg::REG_ALPHA: alpha = val[15:0];
      wec_pkg::REG_INV:   inv   = val[7:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function void take_item(bit mode, bit [2:0] w, bit b, bit [15:0] ms);
    wheel_report_t r;
    longint scale_q8;
    longint span;
    longint delta;
    longint raw;
    longint nudge;
    longint sum;
    logic [wec_pkg::CNT_W-1:0] dv;
    scale_q8 = 64'sd15360000;
    if (!mode) begin
      r.wheel = w;
      r.last  = 1'b1;
      if (w >= wec_pkg::WHEELS_DEF) begin
        r.cnt = '0;
        r.spd = '0;
      end else begin
        if (b ^ inv[w]) counts[w] = counts[w] + 16'd1;
        else counts[w] = counts[w] - 16'd1;
        r.cnt = counts[w];
        r.spd = speeds[w];
      end
      awaited.push_back(r);
    end else if (ms != 16'd0) begin
      span = longint'(ppr == 16'd0 ? 16'd1 : ppr) * longint'(ms);
      for (int i = 0; i < wec_pkg::WHEELS_DEF; i++) begin
        dv    = counts[i] - marks[i];
        delta = longint'($signed(dv));
        raw   = (delta * scale_q8) / span;
        nudge = ((raw - longint'(speeds[i])) * longint'(alpha)) >>> 16;
        sum   = longint'(speeds[i]) + nudge;
        if (sum > 64'sd2147483647) begin
          sum = 64'sd2147483647;
          clamps++;
        end else if (sum < -64'sd2147483648) begin
          sum = -64'sd2147483648;
          clamps++;
        end
        speeds[i] = sum[31:0];
        marks[i]  = counts[i];
        r.wheel = 3'(i);
        r.cnt   = counts[i];
        r.spd   = speeds[i];
        r.last  = (i == wec_pkg::WHEELS_DEF - 1);
        awaited.push_back(r);
      end
    end
  endfunction

  function void note_miss(string field, longint want, longint got);
    errors++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endfunction

  function void match_report(logic [2:0] w, logic [15:0] c, logic [31:0] s, logic l);
    wheel_report_t e;
    if (awaited.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none actual wheel %0d count %0d speed %0d",
               $time, w, $signed(c), $signed(s));
      return;
    end
    e = awaited.pop_front();
    compared++;
    if (w !== e.wheel) note_miss("wheel_out", longint'(e.wheel), longint'(w));
    if (c !== e.cnt)
      note_miss("pulse_count", longint'($signed(e.cnt)), longint'($signed(c)));
    if (s !== e.spd)
      note_miss("speed_rpm_q8", longint'($signed(e.spd)), longint'($signed(s)));
    if (l !== e.last) note_miss("last_of_run", longint'(e.last), longint'(l));
  endfunction
endclass

module wheel_encoder_count_and_speed_core_test;

  localparam int NW = wec_pkg::WHEELS_DEF;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 200;

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [wec_pkg::PADDR_W-1:0] paddr;
  logic [wec_pkg::PDATA_W-1:0] pwdata;
  logic [wec_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  wec_in_if  in_ch ();
  wec_out_if out_ch ();

  wheel_speed_board board = new();

  bit calm_send;
  int n_edges;
  int n_absent;
  int n_ticks;
  int n_idle_ticks;
  int n_settings;

  wheel_encoder_count_and_speed_core #(.WHEELS(NW)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .din     (in_ch),
    .dout    (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("timeout with %0d results still awaited", board.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_ms();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(1, 20));
    if (r < 85) return 16'($urandom_range(21, 1000));
    return 16'($urandom_range(1, 65535));
  endfunction

  // receiver stalls, with calm windows
  initial begin
    int hold;
    int window;
    bit steady;
    hold = 0;
    window = 0;
    steady = 1'b0;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (window == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        window = $urandom_range(50, 300);
      end
      window--;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        hold = pick_gap() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      board.match_report(out_ch.wheel_out, out_ch.pulse_count, out_ch.speed_rpm_q8,
                         out_ch.last_of_run);
  end

  task automatic drive_din(bit mode, bit [2:0] w, bit b, bit [15:0] ms);
    int gap;
    gap = (calm_send || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.wheel      <= w;
    in_ch.b_level    <= b;
    in_ch.elapsed_ms <= ms;
    do @(posedge clk); while (!in_ch.ready);
    board.take_item(mode, w, b, ms);
    if (!mode) begin
      if (w >= NW) n_absent++;
      else n_edges++;
    end else if (ms == 16'd0) n_idle_ticks++;
    else n_ticks++;
  endtask

  task automatic send_edge(bit [2:0] w, bit b);
    drive_din(1'b0, w, b, 16'($urandom));
  endtask

  task automatic send_tick(bit [15:0] ms);
    drive_din(1'b1, 3'($urandom), 1'($urandom), ms);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(logic [15:0] ppr, logic [15:0] alpha, logic [7:0] inv);
    settle();
    write_reg(wec_pkg::REG_PPR, {16'($urandom), ppr});
    write_reg(wec_pkg::REG_ALPHA, {16'($urandom), alpha});
    write_reg(wec_pkg::REG_INV, {24'($urandom), inv});
    write_reg(REG_SPARE, $urandom);
    n_settings++;
    calm_send = ($urandom_range(0, 2) == 0);
  endtask

  task automatic random_traffic(int n);
    int sent;
    int pick;
    bit [2:0] w;
    bit dir;
    bit up [NW];
    sent = 0;
    for (int i = 0; i < NW; i++) up[i] = 1'($urandom);
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        w = 3'($urandom_range(0, NW - 1));
        if ($urandom_range(0, 19) == 0) up[w] = ~up[w];
        dir = ($urandom_range(0, 9) < 8) ? up[w] : ~up[w];
        send_edge(w, dir ^ board.inv[w]);
        sent++;
      end else if (pick < 82) begin
        send_tick(pick_ms());
        sent++;
      end else if (pick < 90) begin
        send_edge(3'($urandom_range(NW, 7)), 1'($urandom));
        sent++;
      end else if (pick < 95) begin
        send_tick(16'd0);
      end else if (pick < 97) begin
        drain();
      end else begin
        send_edge(3'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  // long opposite runs at one pulse per revolution drive both speeds into the clamps
  task automatic clamp_run(int len);
    int ups;
    int downs;
    ups = len;
    downs = len;
    apply_setting(16'd1, 16'hFFFF, 8'($urandom));
    send_tick(16'd1);
    while (ups + downs > 0) begin
      if (downs == 0 || (ups > 0 && $urandom_range(0, 1) == 0)) begin
        send_edge(3'd0, 1'b1 ^ board.inv[0]);
        ups--;
      end else begin
        send_edge(3'd1, 1'b0 ^ board.inv[1]);
        downs--;
      end
    end
    send_tick(16'd1);
    send_tick(16'd1);
    random_traffic(12);
  endtask

  initial begin
    rst = 1'b1;
    calm_send = 1'b0;
    n_edges = 0;
    n_absent = 0;
    n_ticks = 0;
    n_idle_ticks = 0;
    n_settings = 0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.wheel = '0;
    in_ch.b_level = 1'b0;
    in_ch.elapsed_ms = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_edge(3'd0, 1'b1);
    send_edge(3'd0, 1'b0);
    send_edge(3'd0, 1'b1);
    send_edge(3'd1, 1'b0);
    send_edge(3'd1, 1'b1);
    send_edge(3'd1, 1'b0);
    send_edge(3'd2, 1'b1);
    send_edge(3'd7, 1'b0);
    send_edge(3'd5, 1'b1);
    send_tick(16'd0);
    send_tick(16'd1);
    send_edge(3'd0, 1'b1);
    send_tick(16'hFFFF);
    send_edge(3'd1, 1'b1);
    send_edge(3'd1, 1'b1);
    send_tick(16'h8000);
    apply_setting(16'd0, 16'd40000, 8'h00);
    send_edge(3'd0, 1'b1);
    send_edge(3'd0, 1'b1);
    send_tick(16'd1);
    send_tick(16'd3);
    send_edge(3'd0, 1'b0);
    send_edge(3'd1, 1'b0);
    send_tick(16'd7);

    clamp_run(145);
    apply_setting(16'd0, 16'd32768, 8'hFF);
    random_traffic(16);
    apply_setting(16'hFFFF, 16'd0, 8'h00);
    random_traffic(16);
    apply_setting(16'hFFFF, 16'hFFFF, 8'hAA);
    random_traffic(16);
    apply_setting(16'd13, 16'd16384, 8'h02);
    random_traffic(16);
    for (int k = 0; k < 3; k++) begin
      apply_setting(($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 64)) : 16'($urandom),
                    16'($urandom), 8'($urandom));
      random_traffic(16);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d edges on present wheels, %0d on absent ones,", n_edges, n_absent);
    $display("%0d speed ticks, %0d empty ticks, %0d register settings, %0d clamped speeds",
             n_ticks, n_idle_ticks, n_settings, board.clamps);
    $display("%0d results compared, %0d mismatches", board.compared, board.errors);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
